// ===== hw/rtl/humidity_temp_frame_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// Humidity/temperature frame decoder: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_FRAME_DECODER_DEFINES_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_DEFINES_SVH

// Check that a condition holds at every clock edge out of reset
`define HFD_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a consequence holds in the same cycle as its antecedent
`define HFD_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/hfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Humidity/temperature frame decoder package
// Widths, constants, frame assembler states and the CRC-8 byte step.
// ----------------------------------------------------------------------------
package hfd_pkg;

  localparam int DATA_W = 8;
  localparam int RAW_W  = 16;
  localparam int TEMP_W = 12;
  localparam int HUM_W  = 10;

  localparam logic [DATA_W-1:0] CRC_POLY = 8'h31;
  localparam logic [DATA_W-1:0] CRC_INIT = 8'hFF;

  // Queue between frame assembler and converter (power of two)
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Conversion constants: q = floor((scale*raw + ROUND_BIAS) / DIVISOR)
  localparam int TEMP_SCALE  = 1750;
  localparam int HUM_SCALE   = 1000;
  localparam int ROUND_BIAS  = 32767;
  localparam int DIVISOR     = 65535;
  localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 12'sd450;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN    = -12'sd400;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX    = 12'sd1250;

  // Frame assembler position: which byte is expected next
  typedef enum logic [2:0] {
    POS_IDLE  = 3'd0,
    POS_T_LSB = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_MSB = 3'd3,
    POS_H_LSB = 3'd4,
    POS_H_CRC = 3'd5
  } pos_t;

  // One assembled frame handed to the converter
  typedef struct packed {
    logic [RAW_W-1:0] temp_raw;
    logic [RAW_W-1:0] hum_raw;
    logic             ok;
  } frame_t;

  // CRC-8, MSB first, one byte
  function automatic logic [DATA_W-1:0] crc8_step(input logic [DATA_W-1:0] crc,
                                                  input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] c;
    int                i;
    c = crc ^ b;
    for (i = 0; i < DATA_W; i++) begin
      if (c[DATA_W-1]) begin
        c = {c[DATA_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[DATA_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/hfd_front.sv =====
// ----------------------------------------------------------------------------
// Frame assembler
// Takes one byte per transfer, tracks position, checks both CRCs and pushes
// one assembled frame to the queue after the humidity checksum byte.
// ----------------------------------------------------------------------------
`include "humidity_temp_frame_decoder_defines.svh"

module hfd_front import hfd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [DATA_W-1:0] data_byte,
  input  logic              frame_start,
  input  logic              q_full,
  output logic              q_push,
  output frame_t            q_frame
);

  pos_t              pos, pos_next;
  logic [DATA_W-1:0] crc, crc_next;
  logic [RAW_W-1:0]  temp_raw, temp_raw_next;
  logic [RAW_W-1:0]  hum_raw, hum_raw_next;
  logic              temp_ok, temp_ok_next;

  // Hold position and check state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= POS_IDLE;
      crc     <= CRC_INIT;
      temp_ok <= 1'b0;
    end else begin
      pos     <= pos_next;
      crc     <= crc_next;
      temp_ok <= temp_ok_next;
    end
  end

  // Hold raw words
  always_ff @(posedge clk) begin
    temp_raw <= temp_raw_next;
    hum_raw  <= hum_raw_next;
  end

  // Advance on each accepted byte; a start flag restarts the frame
  always_comb begin
    pos_next      = pos;
    crc_next      = crc;
    temp_raw_next = temp_raw;
    hum_raw_next  = hum_raw;
    temp_ok_next  = temp_ok;
    q_push        = 1'b0;
    q_frame       = '{temp_raw: temp_raw, hum_raw: hum_raw,
                      ok: temp_ok && (crc == data_byte)};
    if (accept) begin
      if (frame_start) begin
        pos_next      = POS_T_LSB;
        crc_next      = crc8_step(CRC_INIT, data_byte);
        temp_raw_next = {data_byte, 8'h00};
      end else begin
        unique case (pos)
          POS_IDLE: begin
            pos_next = POS_IDLE;
          end
          POS_T_LSB: begin
            pos_next      = POS_T_CRC;
            crc_next      = crc8_step(crc, data_byte);
            temp_raw_next = {temp_raw[RAW_W-1:DATA_W], data_byte};
          end
          POS_T_CRC: begin
            pos_next     = POS_H_MSB;
            temp_ok_next = (crc == data_byte);
            crc_next     = CRC_INIT;
          end
          POS_H_MSB: begin
            pos_next     = POS_H_LSB;
            crc_next     = crc8_step(CRC_INIT, data_byte);
            hum_raw_next = {data_byte, 8'h00};
          end
          POS_H_LSB: begin
            pos_next     = POS_H_CRC;
            crc_next     = crc8_step(crc, data_byte);
            hum_raw_next = {hum_raw[RAW_W-1:DATA_W], data_byte};
          end
          POS_H_CRC: begin
            pos_next = POS_IDLE;
            crc_next = CRC_INIT;
            q_push   = 1'b1;
          end
          default: begin
            pos_next = POS_IDLE;
          end
        endcase
      end
    end
  end

  // The top level accepts bytes only while the queue has room
  `HFD_ASSERT_IMPLY(a_push_room, q_push, !q_full, "frame pushed into full queue")

endmodule

// ===== hw/rtl/hfd_queue.sv =====
// ----------------------------------------------------------------------------
// Frame queue
// Short FIFO of assembled frames between the assembler and the converter.
// ----------------------------------------------------------------------------
`include "humidity_temp_frame_decoder_defines.svh"

module hfd_queue import hfd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  frame_t wdata,
  output logic   full,
  output logic   empty,
  input  logic   pop,
  output frame_t rdata
);

  frame_t            mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Store pushed frame
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  `HFD_ASSERT_ALWAYS(a_count_range, count <= QCNT_W'(QDEPTH), "queue count overflow")

endmodule

// ===== hw/rtl/hfd_back.sv =====
// ----------------------------------------------------------------------------
// Frame converter
// Three-stage pipeline: constant multiply, quotient estimate by 65535,
// correction with offset and clamp into the result register.
// ----------------------------------------------------------------------------
`include "humidity_temp_frame_decoder_defines.svh"

module hfd_back import hfd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_empty,
  input  frame_t                   q_frame,
  output logic                     q_pop,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [TEMP_W-1:0] temperature_tenths,
  output logic [HUM_W-1:0]         humidity_tenths,
  output logic                     crc_ok
);

  localparam int X_W = 27;  // holds 1750*65535 + 32767
  localparam int Q_W = 11;  // quotient up to 1750
  localparam int R_W = 17;  // remainder below twice the divisor

  // Estimate floor(x/65535) as (x + x>>16) >> 16; low by at most one
  function automatic logic [Q_W+R_W-1:0] div_est(input logic [X_W-1:0] x);
    logic [X_W:0]   sum;
    logic [Q_W-1:0] q;
    logic [X_W:0]   r;
    sum = {1'b0, x} + (X_W+1)'(x[X_W-1:16]);
    q   = sum[16+Q_W-1:16];
    r   = {1'b0, x} - {1'b0, q, 16'h0000} + (X_W+1)'(q);
    return {q, r[R_W-1:0]};
  endfunction

  logic           adv;
  logic           s1_v, s2_v, out_valid;
  logic [X_W-1:0] s1_xt, s1_xh;
  logic           s1_ok;
  logic [Q_W-1:0] s2_qt, s2_qh;
  logic [R_W-1:0] s2_rt, s2_rh;
  logic           s2_ok;
  logic [X_W-1:0] xt_in, xh_in;
  logic [Q_W-1:0] qt_c, qh_c;
  logic signed [TEMP_W-1:0] t_off, t_clamp;

  // Advance the whole pipeline whenever the result slot is free or drains
  assign adv   = !out_valid || pop;
  assign q_pop = adv && !q_empty;
  assign empty = !out_valid;

  // Stage 1 operands
  assign xt_in = X_W'(q_frame.temp_raw) * X_W'(TEMP_SCALE) + X_W'(ROUND_BIAS);
  assign xh_in = X_W'(q_frame.hum_raw) * X_W'(HUM_SCALE) + X_W'(ROUND_BIAS);

  // Correct quotient, apply offset and clamp
  always_comb begin
    qt_c  = s2_qt + Q_W'(s2_rt >= R_W'(DIVISOR));
    qh_c  = s2_qh + Q_W'(s2_rh >= R_W'(DIVISOR));
    t_off = $signed({1'b0, qt_c}) - TEMP_OFFSET;
    if (t_off > TEMP_MAX) begin
      t_clamp = TEMP_MAX;
    end else if (t_off < TEMP_MIN) begin
      t_clamp = TEMP_MIN;
    end else begin
      t_clamp = t_off;
    end
  end

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_v      <= !q_empty;
      s2_v      <= s1_v;
      out_valid <= s2_v;
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_xt                <= xt_in;
      s1_xh                <= xh_in;
      s1_ok                <= q_frame.ok;
      {s2_qt, s2_rt}       <= div_est(s1_xt);
      {s2_qh, s2_rh}       <= div_est(s1_xh);
      s2_ok                <= s1_ok;
      temperature_tenths   <= s2_ok ? t_clamp : '0;
      humidity_tenths      <= s2_ok ? qh_c[HUM_W-1:0] : '0;
      crc_ok               <= s2_ok;
    end
  end

  `HFD_ASSERT_IMPLY(a_fail_zero, out_valid && !crc_ok,
                    temperature_tenths == '0 && humidity_tenths == '0,
                    "nonzero values on checksum failure")
  `HFD_ASSERT_IMPLY(a_temp_range, out_valid,
                    temperature_tenths >= TEMP_MIN && temperature_tenths <= TEMP_MAX,
                    "temperature out of clamp range")

endmodule

// ===== hw/rtl/humidity_temp_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// Humidity/temperature frame decoder
// Decodes six-byte measurement frames into temperature, humidity and a
// checksum flag.
// ----------------------------------------------------------------------------
// Push one frame byte per cycle, with frame_start on the first byte. The
// frame is a temperature word, its CRC-8, a humidity word and its CRC-8.
// Bytes go in at one per cycle while full is low; full rises only when two
// decoded frames already wait for conversion and results are not popped.
// When the sixth byte is taken, the frame enters the queue at that same edge;
// it then passes the multiply, quotient and clamp stages of the converter,
// which all hold while a result waits unpopped at the output. A start
// flag in mid-frame drops the partial frame; bytes without a start while
// idle are ignored. On a checksum failure both values read zero.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder import hfd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [DATA_W-1:0]        data_byte,
  input  logic                     frame_start,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [TEMP_W-1:0] temperature_tenths,
  output logic [HUM_W-1:0]         humidity_tenths,
  output logic                     crc_ok
);

  logic   accept;
  logic   q_push, q_full, q_empty, q_pop;
  frame_t q_wdata, q_rdata;

  // Take a byte only while the frame queue has room
  assign full   = q_full;
  assign accept = push && !q_full;

  hfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_frame     (q_wdata)
  );

  hfd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .empty (q_empty),
    .pop   (q_pop),
    .rdata (q_rdata)
  );

  hfd_back u_back (
    .clk                (clk),
    .rst                (rst),
    .q_empty            (q_empty),
    .q_frame            (q_rdata),
    .q_pop              (q_pop),
    .empty              (empty),
    .pop                (pop),
    .temperature_tenths (temperature_tenths),
    .humidity_tenths    (humidity_tenths),
    .crc_ok             (crc_ok)
  );

endmodule
